// File: hw/rtl/sacr_pkg.sv
// ----------------------------------------------------------------------------
// sacr_pkg
// Shared types and constants for the random-replacement set-associative
// cache tag store.
// ----------------------------------------------------------------------------
package sacr_pkg;

  localparam int ADDR_BITS        = 32;
  localparam int CACHE_BYTES_LOG2 = 15;
  localparam int BLOCK_BYTES_LOG2 = 6;
  localparam int MAX_WAYS_LOG2    = 3;

  localparam int LINES_LOG2 = CACHE_BYTES_LOG2 - BLOCK_BYTES_LOG2;
  localparam int ROWS_LOG2  = LINES_LOG2 - MAX_WAYS_LOG2;
  localparam int ROWS       = 1 << ROWS_LOG2;
  localparam int LANES      = 1 << MAX_WAYS_LOG2;
  localparam int TAG_W      = ADDR_BITS - CACHE_BYTES_LOG2 + MAX_WAYS_LOG2;
  localparam int EXP_W      = 2;
  localparam int SHIFT_W    = 6;

  localparam int LFSR_W = 16;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_ONE  = 16'h0001;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LFSR_W;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_EXP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED     = 1'd1;

  localparam int CNT_W = 32;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef entry_t [LANES-1:0] row_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

endpackage

// File: hw/rtl/sacr_ram.sv
// ----------------------------------------------------------------------------
// sacr_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sacr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/set_assoc_cache_random_replace_core.sv
// The tag row of an accepted transaction is read into the RAM's registered output;
// the lookup state commits the result once the output is free, and only then is a
// new transaction taken. A 64 x 168 bit RAM holds the tag rows; a set is read whole, and a miss writes one way.
// Reset clears the per-row valid flags at once, so no clearing pass is needed;
// counters go to zero, associativity to direct mapped and the LFSR to one.
// ----------------------------------------------------------------------------
// set_assoc_cache_random_replace_core
// Tag store of a 32 KiB set-associative cache with LFSR-based random
// replacement and saturating hit and miss counters.
// ----------------------------------------------------------------------------
module set_assoc_cache_random_replace_core import sacr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ADDR_BITS-1:0]  address_i,

  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  hit_o,
  output logic [2:0]            way_used_o,
  output logic                  evicted_o,
  output logic [CNT_W-1:0]      hit_count_o,
  output logic [CNT_W-1:0]      miss_count_o,

  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  state_e state_q, state_d;

  logic [EXP_W-1:0]          ways_exp_q;
  logic [LFSR_W-1:0]         lfsr_q, lfsr_d;
  logic [CNT_W-1:0]          hits_q, hits_d;
  logic [CNT_W-1:0]          misses_q, misses_d;
  logic [ROWS-1:0]           row_vld_q;

  logic [TAG_W-1:0]          tag_q;
  logic [ROWS_LOG2-1:0]      row_q;
  logic [MAX_WAYS_LOG2-1:0]  lane_base_q;

  logic                      out_valid_q;
  logic                      hit_q;
  logic [2:0]                way_q;
  logic                      evicted_q;

  logic                      accept;
  logic                      commit;
  logic                      out_free;
  logic                      ram_re;
  logic                      ram_we;

  logic [LINES_LOG2-1:0]     base;
  logic [SHIFT_W-1:0]        tag_shift;
  logic [TAG_W-1:0]          tag_in;
  logic [MAX_WAYS_LOG2-1:0]  way_mask;

  logic [$bits(row_t)-1:0]   ram_rdata;
  row_t                      row_rd;
  row_t                      row_wr;

  logic                      hit;
  logic [MAX_WAYS_LOG2-1:0]  hit_lane;
  logic                      free_found;
  logic [MAX_WAYS_LOG2-1:0]  free_lane;
  logic [MAX_WAYS_LOG2-1:0]  sel_lane;
  logic                      evict;

  // Address split
  assign base      = address_i[CACHE_BYTES_LOG2-1:BLOCK_BYTES_LOG2] << ways_exp_q;
  assign tag_shift = SHIFT_W'(CACHE_BYTES_LOG2) - SHIFT_W'(ways_exp_q);
  assign tag_in    = TAG_W'(address_i >> tag_shift);
  assign way_mask  = MAX_WAYS_LOG2'((4'd1 << ways_exp_q) - 4'd1);

  // Control FSM
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_LOOKUP;
      ST_LOOKUP: if (out_free)   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    ram_re     = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        ram_re     = in_valid_i;
      end
      ST_LOOKUP: commit = out_free;
      default: ;
    endcase
  end

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Tag RAM: one row holds all lanes a set can occupy
  sacr_ram #(
    .Width($bits(row_t)),
    .Depth(ROWS)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(row_q),
    .wdata_i(row_wr),
    .re_i   (ram_re),
    .raddr_i(base[LINES_LOG2-1:MAX_WAYS_LOG2]),
    .rdata_o(ram_rdata)
  );

  assign row_rd = row_vld_q[row_q] ? row_t'(ram_rdata) : '0;

  // Way lookup; loops run low to high priority so the lowest way wins
  always_comb begin
    hit        = 1'b0;
    hit_lane   = '0;
    free_found = 1'b0;
    free_lane  = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if ((MAX_WAYS_LOG2'(l) & ~way_mask) == lane_base_q) begin
        if (row_rd[l].valid && row_rd[l].tag == tag_q) begin
          hit      = 1'b1;
          hit_lane = MAX_WAYS_LOG2'(l);
        end
        if (!row_rd[l].valid) begin
          free_found = 1'b1;
          free_lane  = MAX_WAYS_LOG2'(l);
        end
      end
    end
  end

  always_comb begin
    evict    = 1'b0;
    sel_lane = hit_lane;
    if (!hit) begin
      if (free_found) begin
        sel_lane = free_lane;
      end else begin
        sel_lane = lane_base_q | (lfsr_q[MAX_WAYS_LOG2-1:0] & way_mask);
        evict    = 1'b1;
      end
    end
  end

  always_comb begin
    row_wr                 = row_rd;
    row_wr[sel_lane].valid = 1'b1;
    row_wr[sel_lane].tag   = tag_q;
  end

  assign ram_we = commit && !hit;

  // Counters and LFSR
  always_comb begin
    hits_d   = hits_q;
    misses_d = misses_q;
    lfsr_d   = lfsr_q;
    if (commit) begin
      if (hit) begin
        if (hits_q != '1) hits_d = hits_q + CNT_W'(1);
      end else begin
        if (misses_q != '1) misses_d = misses_q + CNT_W'(1);
      end
      if (evict) begin
        lfsr_d = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
      end
    end
    if (cfg_we_i && cfg_index_i == CFG_SEED) begin
      lfsr_d = (cfg_wdata_i == '0) ? LFSR_ONE : cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ways_exp_q  <= '0;
      lfsr_q      <= LFSR_ONE;
      hits_q      <= '0;
      misses_q    <= '0;
      row_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      lfsr_q   <= lfsr_d;
      hits_q   <= hits_d;
      misses_q <= misses_d;
      if (cfg_we_i && cfg_index_i == CFG_WAYS_EXP) begin
        ways_exp_q <= cfg_wdata_i[EXP_W-1:0];
      end
      if (ram_we) begin
        row_vld_q[row_q] <= 1'b1;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tag_q       <= tag_in;
      row_q       <= base[LINES_LOG2-1:MAX_WAYS_LOG2];
      lane_base_q <= base[MAX_WAYS_LOG2-1:0];
    end
    if (commit) begin
      hit_q     <= hit;
      way_q     <= 3'(sel_lane & way_mask);
      evicted_q <= evict;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign way_used_o   = way_q;
  assign evicted_o    = evicted_q;
  assign hit_count_o  = hits_q;
  assign miss_count_o = misses_q;

endmodule
